[hw/rtl/alpc_pkg.sv]
// Shared types, constants and helpers for the checked ASCII record parser.
`timescale 1ns / 1ps

package alpc_pkg;

	localparam logic [10:0] BUFFER_BYTES = 11'd1024;
	localparam logic [5:0]  MAX_FIELDS   = 6'd32;
	localparam logic [10:0] POS_MAX      = 11'd2047;
	localparam logic [31:0] CRC_POLY     = 32'hEDB88320;

	localparam logic [7:0] CHAR_HASH  = 8'h23;
	localparam logic [7:0] CHAR_STAR  = 8'h2A;
	localparam logic [7:0] CHAR_QUOTE = 8'h22;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_SEMI  = 8'h3B;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;

	// Hex field after the star: eight digits, record end right after them.
	localparam logic [11:0] HEX_DIGITS = 12'd8;
	localparam logic [11:0] CRLF_SLOT  = 12'd9;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// One classified byte as it travels from front end to back end.
	typedef struct packed {
		logic [7:0] byte_val;
		logic       starts_record;
		logic       is_hash;
		logic       is_star;
		logic       is_quote;
		logic       is_comma;
		logic       is_semi;
		logic       is_crlf;
		logic       is_print;
		logic       is_hex;
		logic [3:0] hex_nibble;
	} alpc_item_t;

	// Reflected CRC32 byte update on the complemented register.
	function automatic logic [31:0] crc_fold(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = ~c;
		r = r ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return ~r;
	endfunction

endpackage

[hw/rtl/ascii_log_parser_crc32.sv]
// Top level: checked ASCII record parser with running CRC32.
// A result beat is registered in the back end after its input byte has passed through the queue.
// Throughput: one byte per cycle while the output is not stalled; the CRC32 byte fold is combinational.
// A four-beat queue lets input and output stall independently.
// Reset empties the queue, drops any pending result, clears all record state and the CRC start value.
`timescale 1ns / 1ps

module ascii_log_parser_crc32 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,    // crc_start_value
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
	input  logic [0:0]  s_axis_tuser,   // [0] starts_record
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] in_sync, [1] delim_valid, [11:2] delim_position,
	// [17:12] field_count, [23:18] header_field_count
	output logic [23:0] m_axis_tdata,
	output logic        m_axis_tlast    // record_done
);
	import alpc_pkg::*;

	logic       push;
	alpc_item_t push_item;
	logic       queue_full;
	logic       pop;
	logic       pop_valid;
	alpc_item_t pop_item;

	alpc_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.push          (push),
		.push_item     (push_item),
		.queue_full    (queue_full)
	);

	alpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_item  (pop_item)
	);

	alpc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.item_valid    (pop_valid),
		.item          (pop_item),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

[hw/rtl/alpc_front.sv]
// Front end: take input beats and classify each character.
`timescale 1ns / 1ps

module alpc_front (
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [7:0]          s_axis_tdata,   // [7:0] byte_in
	input  logic [0:0]          s_axis_tuser,   // [0] starts_record
	output logic                push,
	output alpc_pkg::alpc_item_t push_item,
	input  logic                queue_full
);
	import alpc_pkg::*;

	logic [7:0] ch;
	logic       is_digit;
	logic       is_upper;
	logic       is_lower;

	assign ch            = s_axis_tdata;
	assign s_axis_tready = !queue_full;
	assign push          = s_axis_tvalid && !queue_full;

	always_comb begin
		is_digit = ch inside {[8'h30:8'h39]};
		is_upper = ch inside {[8'h41:8'h46]};
		is_lower = ch inside {[8'h61:8'h66]};

		push_item.byte_val      = ch;
		push_item.starts_record = s_axis_tuser[0];
		push_item.is_hash       = (ch == CHAR_HASH);
		push_item.is_star       = (ch == CHAR_STAR);
		push_item.is_quote      = (ch == CHAR_QUOTE);
		push_item.is_comma      = (ch == CHAR_COMMA);
		push_item.is_semi       = (ch == CHAR_SEMI);
		push_item.is_crlf       = (ch == CHAR_CR) || (ch == CHAR_LF);
		push_item.is_print      = ch inside {[8'h20:8'h7E]};
		push_item.is_hex        = is_digit || is_upper || is_lower;
		// letters map as low nibble + 9 (A/a = 1 + 9)
		push_item.hex_nibble    = is_digit ? ch[3:0] : (ch[3:0] + 4'd9);
	end

endmodule

[hw/rtl/alpc_queue.sv]
// Short queue of classified bytes between front end and back end.
`timescale 1ns / 1ps

module alpc_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  alpc_pkg::alpc_item_t push_item,
	output logic                 full,
	input  logic                 pop,
	output logic                 pop_valid,
	output alpc_pkg::alpc_item_t pop_item
);
	import alpc_pkg::*;

	alpc_item_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full      = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hw/rtl/alpc_back.sv]
// Back end: per-record state, CRC fold, hex check and the result register.
`timescale 1ns / 1ps

module alpc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [31:0]          cfg_wr_data,
	input  logic                 item_valid,
	input  alpc_pkg::alpc_item_t item,
	output logic                 pop,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [23:0]          m_axis_tdata,
	output logic                 m_axis_tlast
);
	import alpc_pkg::*;

	logic [31:0] crc_start_q;
	logic [10:0] byte_pos_q;
	logic        rso_q;
	logic        quote_q;
	logic [5:0]  dcount_q;
	logic [5:0]  hdr_q;
	logic [31:0] crc_q;
	logic [10:0] star_q;
	logic [31:0] hexv_q;
	logic        hexok_q;

	logic        out_valid_q;
	logic        sync_q;
	logic        done_q;
	logic        dvalid_q;
	logic [9:0]  dpos_q;
	logic [5:0]  fcount_q;
	logic [5:0]  hcount_q;

	logic [11:0] len;
	logic        init;
	logic        rso_cur;
	logic        quote_cur;
	logic [5:0]  dcount_cur;
	logic [5:0]  hdr_cur;
	logic [31:0] crc_cur;
	logic [10:0] star_cur;
	logic [31:0] hexv_cur;
	logic        hexok_cur;
	logic [11:0] star_ext;

	logic [10:0] byte_pos_d;
	logic        rso_d;
	logic        quote_d;
	logic [5:0]  dcount_d;
	logic [5:0]  hdr_d;
	logic [31:0] crc_d;
	logic [10:0] star_d;
	logic [31:0] hexv_d;
	logic        hexok_d;
	logic        sync_d;
	logic        done_d;
	logic        dvalid_d;
	logic [9:0]  dpos_d;
	logic        star_now;
	logic [11:0] len_m1;

	assign pop           = item_valid && (!out_valid_q || m_axis_tready);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = done_q;
	assign m_axis_tdata  = {hcount_q, fcount_q, dpos_q, dvalid_q, sync_q};

	always_comb begin
		len        = item.starts_record ? 12'd1 : ({1'b0, byte_pos_q} + 12'd1);
		len_m1     = len - 12'd1;
		byte_pos_d = (len > {1'b0, POS_MAX}) ? POS_MAX : len[10:0];
		init       = item.starts_record && item.is_hash;
		rso_cur    = item.starts_record ? item.is_hash : rso_q;

		// a '#' start reloads the whole record context
		quote_cur  = init ? 1'b0 : quote_q;
		dcount_cur = init ? 6'd0 : dcount_q;
		hdr_cur    = init ? 6'd0 : hdr_q;
		crc_cur    = init ? crc_start_q : crc_q;
		star_cur   = init ? BUFFER_BYTES : star_q;
		hexv_cur   = init ? 32'd0 : hexv_q;
		hexok_cur  = init ? 1'b1 : hexok_q;
		star_ext   = {1'b0, star_cur};

		rso_d    = rso_cur;
		quote_d  = quote_cur;
		dcount_d = dcount_cur;
		hdr_d    = hdr_cur;
		crc_d    = crc_cur;
		star_d   = star_cur;
		hexv_d   = hexv_cur;
		hexok_d  = hexok_cur;
		sync_d   = 1'b0;
		done_d   = 1'b0;
		dvalid_d = 1'b0;
		dpos_d   = 10'd0;
		star_now = 1'b0;

		if (!rso_cur) begin
			sync_d = 1'b0;
		end else if (len > {1'b0, BUFFER_BYTES}) begin
			sync_d = 1'b0;
			rso_d  = 1'b0;
		end else begin
			star_now = !quote_cur && item.is_star;

			if (quote_cur) begin
				sync_d = item.is_print;
			end else if (item.is_star) begin
				sync_d = (len < star_ext);
			end else if (item.is_crlf) begin
				sync_d = (star_ext + CRLF_SLOT == len) && hexok_cur && (~crc_cur == hexv_cur);
				done_d = 1'b1;
			end else if (star_ext + HEX_DIGITS < len) begin
				sync_d = 1'b0;
			end else begin
				sync_d = item.is_print;
			end

			if (star_now) begin
				star_d  = len[10:0];
				hexv_d  = 32'd0;
				hexok_d = 1'b1;
			end else if (len >= star_ext + 12'd1 && len <= star_ext + HEX_DIGITS) begin
				if (item.is_hex) begin
					hexv_d = {hexv_cur[27:0], item.hex_nibble};
				end else begin
					hexok_d = 1'b0;
				end
			end

			// fold only bytes after the first byte and ahead of the star, the star itself excluded by the bound
			if (len > 12'd1 && len < {1'b0, star_d}) begin
				crc_d = crc_fold(crc_cur, item.byte_val);
			end

			if (item.is_quote) begin
				quote_d = !quote_cur;
			end else if (!quote_cur && (item.is_comma || item.is_semi || item.is_star)) begin
				if (dcount_cur < MAX_FIELDS) begin
					dvalid_d = 1'b1;
					dpos_d   = len_m1[9:0];
					dcount_d = dcount_cur + 6'd1;
				end
				if (item.is_semi) begin
					hdr_d = dcount_d;
				end
			end

			// drop sync on failure or at record end
			if (!sync_d || done_d) begin
				rso_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_start_q <= 32'd0;
			byte_pos_q  <= '0;
			rso_q       <= 1'b0;
			quote_q     <= 1'b0;
			dcount_q    <= '0;
			hdr_q       <= '0;
			crc_q       <= 32'd0;
			star_q      <= BUFFER_BYTES;
			hexv_q      <= 32'd0;
			hexok_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				crc_start_q <= cfg_wr_data;
			end
			if (pop) begin
				byte_pos_q  <= byte_pos_d;
				rso_q       <= rso_d;
				quote_q     <= quote_d;
				dcount_q    <= dcount_d;
				hdr_q       <= hdr_d;
				crc_q       <= crc_d;
				star_q      <= star_d;
				hexv_q      <= hexv_d;
				hexok_q     <= hexok_d;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, loaded with each processed beat
	always_ff @(posedge clk) begin
		if (pop) begin
			sync_q   <= sync_d;
			done_q   <= done_d;
			dvalid_q <= dvalid_d;
			dpos_q   <= dpos_d;
			fcount_q <= dcount_d;
			hcount_q <= hdr_d;
		end
	end

endmodule
